FILE: rtl/core/prefix_suffix_gcd_query_unit_assert.svh
// assertion macros shared by the gcd query unit modules
`ifndef PREFIX_SUFFIX_GCD_QUERY_UNIT_ASSERT_SVH
`define PREFIX_SUFFIX_GCD_QUERY_UNIT_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define PSGQ_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is low
`define PSGQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/psgq_pkg.sv
// shared widths, command codes and gcd unit interface types
`default_nettype none

package psgq_pkg;

	localparam int VAL_W = 31;
	localparam int POS_W = 11;
	localparam int SHIFT_W = 5;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef struct packed {
		logic             start;
		logic [VAL_W-1:0] a;
		logic [VAL_W-1:0] b;
	} gcd_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [VAL_W-1:0] result;
	} gcd_rsp_t;

endpackage

`default_nettype wire

FILE: rtl/core/psgq_gcd.sv
// iterative binary gcd unit, one shift or subtract-and-shift per cycle
`default_nettype none
`include "prefix_suffix_gcd_query_unit_assert.svh"

module psgq_gcd (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire psgq_pkg::gcd_req_t req,
	output psgq_pkg::gcd_rsp_t      rsp
);

	logic [psgq_pkg::VAL_W-1:0]   a_q;
	logic [psgq_pkg::VAL_W-1:0]   b_q;
	logic [psgq_pkg::SHIFT_W-1:0] k_q;
	logic                         busy_q;
	logic                         done_q;
	logic [psgq_pkg::VAL_W-1:0]   result_q;

	// operand registers and step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q      <= '0;
			b_q      <= '0;
			k_q      <= '0;
			busy_q   <= 1'b0;
			done_q   <= 1'b0;
			result_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				a_q    <= req.a;
				b_q    <= req.b;
				k_q    <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (a_q == '0) begin
					// one side empty: the other, scaled by common twos, is the answer
					result_q <= b_q << k_q;
					busy_q   <= 1'b0;
					done_q   <= 1'b1;
				end else if (b_q == '0) begin
					result_q <= a_q << k_q;
					busy_q   <= 1'b0;
					done_q   <= 1'b1;
				end else begin
					case ({a_q[0], b_q[0]})
						2'b00: begin
							a_q <= a_q >> 1;
							b_q <= b_q >> 1;
							k_q <= k_q + psgq_pkg::SHIFT_W'(1);
						end
						2'b01: a_q <= a_q >> 1;
						2'b10: b_q <= b_q >> 1;
						default: begin
							// both odd: difference is even, drop its low zero now
							if (a_q >= b_q) begin
								a_q <= (a_q - b_q) >> 1;
							end else begin
								b_q <= (b_q - a_q) >> 1;
							end
						end
					endcase
				end
			end
		end
	end

	assign rsp.busy   = busy_q;
	assign rsp.done   = done_q;
	assign rsp.result = result_q;

	`PSGQ_ASSERT_NOW(a_start_idle, clk, arst_n, req.start, !busy_q, "gcd started while busy")
	`PSGQ_ASSERT_NOW(a_done_idle, clk, arst_n, done_q, !busy_q, "gcd done while still busy")
	`PSGQ_ASSERT_NEXT(a_zero_ends, clk, arst_n, busy_q && !req.start && (a_q == '0 || b_q == '0), done_q && !busy_q, "gcd did not finish on zero operand")

endmodule

`default_nettype wire

FILE: rtl/core/psgq_ram.sv
// simple dual-port ram, one write and one registered read per cycle
`default_nettype none

module psgq_ram #(
	parameter int DEPTH  = 1024,
	parameter int ADDR_W = 10
) (
	input  wire logic                       clk,
	input  wire logic                       we,
	input  wire logic [ADDR_W-1:0]          waddr,
	input  wire logic [psgq_pkg::VAL_W-1:0] wdata,
	input  wire logic [ADDR_W-1:0]          raddr,
	output logic      [psgq_pkg::VAL_W-1:0] rdata
);

	logic [psgq_pkg::VAL_W-1:0] mem [DEPTH];
	logic [psgq_pkg::VAL_W-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/core/prefix_suffix_gcd_query_unit.sv
// A load that the store takes runs the shared binary gcd unit once, for its prefix entry.
// A last load then walks the array backward, one gcd per element for the suffixes.
// A query reaches the result register without a gcd on error, otherwise after one gcd.
// One item is in work at a time; the result register frees the input side at once.
// Reset (arst_n low) clears the element count, ready flag, state and result valid;
// the element, prefix and suffix memories are not cleared.
`default_nettype none
`include "prefix_suffix_gcd_query_unit_assert.svh"

module prefix_suffix_gcd_query_unit #(
	parameter int MAX_ELEMS = 1024
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       item_valid,
	output logic                            item_stall,
	input  wire logic                       cmd,
	input  wire logic [psgq_pkg::VAL_W-1:0] value,
	input  wire logic                       is_last,
	input  wire logic [psgq_pkg::POS_W-1:0] left_pos,
	input  wire logic [psgq_pkg::POS_W-1:0] right_pos,
	output logic                            result_valid,
	input  wire logic                       result_stall,
	output logic      [psgq_pkg::VAL_W-1:0] gcd_out,
	output logic                            error
);

	localparam int CNT_W  = $clog2(MAX_ELEMS + 1);
	localparam int ADDR_W = $clog2(MAX_ELEMS);
	localparam int CMP_W  = (CNT_W > psgq_pkg::POS_W) ? CNT_W : psgq_pkg::POS_W;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LD_GCD,
		ST_SUF_RD,
		ST_SUF_START,
		ST_SUF_GCD,
		ST_Q_RD,
		ST_Q_START,
		ST_Q_GCD,
		ST_OUT
	} state_t;

	state_t                      state_q;
	logic [CNT_W-1:0]            element_count_q;
	logic                        array_ready_q;
	logic [psgq_pkg::VAL_W-1:0]  pre_last_q;
	logic [ADDR_W-1:0]           ld_idx_q;
	logic                        last_q;
	logic [CNT_W-1:0]            sfx_idx_q;
	logic [psgq_pkg::VAL_W-1:0]  acc_q;
	logic [ADDR_W-1:0]           pre_addr_q;
	logic [ADDR_W-1:0]           suf_addr_q;
	logic                        use_pre_q;
	logic                        use_suf_q;
	logic [psgq_pkg::VAL_W-1:0]  res_gcd_q;
	logic                        res_err_q;
	logic                        result_valid_q;
	logic [psgq_pkg::VAL_W-1:0]  gcd_out_q;
	logic                        error_q;

	logic                        item_acc;
	logic [CNT_W-1:0]            cnt_eff;
	logic                        full;
	logic [CNT_W-1:0]            cnt_inc;
	logic [CNT_W-1:0]            sfx_m1;
	logic [CMP_W-1:0]            l_ext;
	logic [CMP_W-1:0]            r_ext;
	logic [CMP_W-1:0]            cnt_ext;
	logic [CMP_W-1:0]            l_m2;
	logic                        q_err;
	logic [psgq_pkg::VAL_W-1:0]  prev_pre;

	logic                        elem_we;
	logic                        pre_we;
	logic                        suf_we;
	logic [ADDR_W-1:0]           suf_waddr;
	logic [psgq_pkg::VAL_W-1:0]  elem_rdata;
	logic [psgq_pkg::VAL_W-1:0]  pre_rdata;
	logic [psgq_pkg::VAL_W-1:0]  suf_rdata;

	psgq_pkg::gcd_req_t          gcd_req;
	psgq_pkg::gcd_rsp_t          gcd_rsp;

	// input handshake
	assign item_stall = (state_q != ST_IDLE);
	assign item_acc   = item_valid && !item_stall;

	// load bookkeeping: a load after a ready array restarts at position one
	assign cnt_eff  = array_ready_q ? '0 : element_count_q;
	assign full     = (cnt_eff == CNT_W'(MAX_ELEMS));
	assign cnt_inc  = element_count_q + CNT_W'(1);
	assign sfx_m1   = sfx_idx_q - CNT_W'(1);
	assign prev_pre = (cnt_eff == '0) ? '0 : pre_last_q;

	// query range check
	assign l_ext   = CMP_W'(left_pos);
	assign r_ext   = CMP_W'(right_pos);
	assign cnt_ext = CMP_W'(element_count_q);
	assign l_m2    = l_ext - CMP_W'(2);
	assign q_err   = !array_ready_q || (left_pos == '0) || (right_pos == '0)
		|| (l_ext > cnt_ext) || (r_ext > cnt_ext);

	// memory write strobes
	assign elem_we   = item_acc && (cmd == psgq_pkg::CMD_LOAD) && !full;
	assign pre_we    = (state_q == ST_LD_GCD) && gcd_rsp.done;
	assign suf_we    = (state_q == ST_SUF_GCD) && gcd_rsp.done;
	assign suf_waddr = sfx_m1[ADDR_W-1:0];

	// gcd unit operand select
	always_comb begin
		gcd_req = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (elem_we) begin
					gcd_req.start = 1'b1;
					gcd_req.a     = prev_pre;
					gcd_req.b     = value;
				end
			end
			ST_SUF_START: begin
				gcd_req.start = 1'b1;
				gcd_req.a     = acc_q;
				gcd_req.b     = elem_rdata;
			end
			ST_Q_START: begin
				gcd_req.start = 1'b1;
				gcd_req.a     = use_pre_q ? pre_rdata : '0;
				gcd_req.b     = use_suf_q ? suf_rdata : '0;
			end
			default: gcd_req = '0;
		endcase
	end

	// sequencer, bookkeeping and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			element_count_q <= '0;
			array_ready_q   <= 1'b0;
			pre_last_q      <= '0;
			ld_idx_q        <= '0;
			last_q          <= 1'b0;
			sfx_idx_q       <= '0;
			acc_q           <= '0;
			pre_addr_q      <= '0;
			suf_addr_q      <= '0;
			use_pre_q       <= 1'b0;
			use_suf_q       <= 1'b0;
			res_gcd_q       <= '0;
			res_err_q       <= 1'b0;
			result_valid_q  <= 1'b0;
			gcd_out_q       <= '0;
			error_q         <= 1'b0;
		end else begin
			// result valid: set when a result is loaded, cleared once the beat is taken
			if ((state_q == ST_OUT) && (!result_valid_q || !result_stall)) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (item_acc && (cmd == psgq_pkg::CMD_LOAD)) begin
						element_count_q <= cnt_eff;
						array_ready_q   <= 1'b0;
						ld_idx_q        <= cnt_eff[ADDR_W-1:0];
						last_q          <= is_last;
						sfx_idx_q       <= cnt_eff;
						acc_q           <= '0;
						if (!full) begin
							state_q <= ST_LD_GCD;
						end else if (is_last) begin
							// store full: value dropped, the mark still closes the array
							state_q <= ST_SUF_RD;
						end
					end else if (item_acc) begin
						pre_addr_q <= l_m2[ADDR_W-1:0];
						suf_addr_q <= r_ext[ADDR_W-1:0];
						use_pre_q  <= (l_ext >= CMP_W'(2));
						use_suf_q  <= (r_ext < cnt_ext);
						if (q_err) begin
							res_gcd_q <= '0;
							res_err_q <= 1'b1;
							state_q   <= ST_OUT;
						end else begin
							state_q <= ST_Q_RD;
						end
					end
				end
				ST_LD_GCD: begin
					if (gcd_rsp.done) begin
						pre_last_q      <= gcd_rsp.result;
						element_count_q <= cnt_inc;
						sfx_idx_q       <= cnt_inc;
						state_q         <= last_q ? ST_SUF_RD : ST_IDLE;
					end
				end
				// backward pass over the elements, one gcd per position
				ST_SUF_RD: begin
					if (sfx_idx_q == '0) begin
						array_ready_q <= 1'b1;
						state_q       <= ST_IDLE;
					end else begin
						state_q <= ST_SUF_START;
					end
				end
				ST_SUF_START: state_q <= ST_SUF_GCD;
				ST_SUF_GCD: begin
					if (gcd_rsp.done) begin
						acc_q     <= gcd_rsp.result;
						sfx_idx_q <= sfx_m1;
						state_q   <= ST_SUF_RD;
					end
				end
				// query: read prefix and suffix, then one gcd
				ST_Q_RD: state_q <= ST_Q_START;
				ST_Q_START: state_q <= ST_Q_GCD;
				ST_Q_GCD: begin
					if (gcd_rsp.done) begin
						res_gcd_q <= gcd_rsp.result;
						res_err_q <= 1'b0;
						state_q   <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!result_valid_q || !result_stall) begin
						gcd_out_q <= res_gcd_q;
						error_q   <= res_err_q;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign gcd_out      = gcd_out_q;
	assign error        = error_q;

	psgq_gcd u_gcd (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (gcd_req),
		.rsp    (gcd_rsp)
	);

	psgq_ram #(
		.DEPTH  (MAX_ELEMS),
		.ADDR_W (ADDR_W)
	) u_elem_ram (
		.clk   (clk),
		.we    (elem_we),
		.waddr (cnt_eff[ADDR_W-1:0]),
		.wdata (value),
		.raddr (sfx_m1[ADDR_W-1:0]),
		.rdata (elem_rdata)
	);

	psgq_ram #(
		.DEPTH  (MAX_ELEMS),
		.ADDR_W (ADDR_W)
	) u_pre_ram (
		.clk   (clk),
		.we    (pre_we),
		.waddr (ld_idx_q),
		.wdata (gcd_rsp.result),
		.raddr (pre_addr_q),
		.rdata (pre_rdata)
	);

	psgq_ram #(
		.DEPTH  (MAX_ELEMS),
		.ADDR_W (ADDR_W)
	) u_suf_ram (
		.clk   (clk),
		.we    (suf_we),
		.waddr (suf_waddr),
		.wdata (gcd_rsp.result),
		.raddr (suf_addr_q),
		.rdata (suf_rdata)
	);

	`PSGQ_ASSERT_NOW(a_count_max, clk, arst_n, 1'b1, element_count_q <= CNT_W'(MAX_ELEMS), "element count above store depth")
	`PSGQ_ASSERT_NEXT(a_query_busy, clk, arst_n, item_acc && (cmd == psgq_pkg::CMD_QUERY), state_q != ST_IDLE, "query beat did not start work")
	`PSGQ_ASSERT_NOW(a_ready_src, clk, arst_n, $rose(array_ready_q), $past(state_q == ST_SUF_RD) && !gcd_rsp.busy, "array ready set outside suffix pass")

endmodule

`default_nettype wire

FILE: tb/prefix_suffix_gcd_query_unit_tb.sv
// testbench for the prefix/suffix gcd range-exclusion query unit, with its own scoreboard
module prefix_suffix_gcd_query_unit_tb;

	localparam int VAL_W = psgq_pkg::VAL_W;
	localparam int POS_W = psgq_pkg::POS_W;
	localparam int STORE_DEPTH = 1024;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int TAIL_CYCLES = 200;
	localparam int HOLD_CYCLES = 600;

	typedef struct {
		logic             cmd;
		logic [VAL_W-1:0] value;
		logic             last;
		logic [POS_W-1:0] lpos;
		logic [POS_W-1:0] rpos;
	} gcd_item_t;

	typedef struct {
		logic [VAL_W-1:0] gcd;
		logic             err;
	} gcd_result_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             item_valid = 1'b0;
	logic             item_stall;
	logic             cmd = psgq_pkg::CMD_LOAD;
	logic [VAL_W-1:0] value = '0;
	logic             is_last = 1'b0;
	logic [POS_W-1:0] left_pos = '0;
	logic [POS_W-1:0] right_pos = '0;
	logic             result_valid;
	logic             result_stall = 1'b0;
	logic [VAL_W-1:0] gcd_out;
	logic             error;

	gcd_item_t   pending_items[$];
	gcd_result_t expected_gcds[$];

	// mirror of the unit's stores
	logic [VAL_W-1:0] element_copy [STORE_DEPTH];
	logic [VAL_W-1:0] prefix_copy  [STORE_DEPTH];
	logic [VAL_W-1:0] suffix_copy  [STORE_DEPTH];
	int unsigned      loaded_count = 0;
	logic             array_complete = 1'b0;

	int send_idle_pct = 13;
	int recv_stall_pct = 79;
	logic hold_go = 1'b0;
	logic hold_done = 1'b0;
	int hold_left = 0;

	int mismatch_count = 0;
	int loads_taken = 0;
	int queries_taken = 0;
	int arrays_done = 0;
	int results_seen = 0;
	int error_results = 0;
	int cycle_count = 0;

	prefix_suffix_gcd_query_unit #(
		.MAX_ELEMS(STORE_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.cmd(cmd),
		.value(value),
		.is_last(is_last),
		.left_pos(left_pos),
		.right_pos(right_pos),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.gcd_out(gcd_out),
		.error(error)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// euclid on 31-bit values, gcd(0, x) = x
	function automatic logic [VAL_W-1:0] gcd_of(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b);
		logic [VAL_W-1:0] x;
		logic [VAL_W-1:0] y;
		logic [VAL_W-1:0] t;
		x = a;
		y = b;
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		return x;
	endfunction

	// update the mirrored stores for one accepted beat, queue the result of a query
	task automatic apply_gcd_beat(gcd_item_t it);
		logic [VAL_W-1:0] prev;
		logic [VAL_W-1:0] acc;
		logic [VAL_W-1:0] pre_g;
		logic [VAL_W-1:0] suf_g;
		gcd_result_t res;
		if (it.cmd == psgq_pkg::CMD_LOAD) begin
			loads_taken++;
			// a load after a complete array starts a new one
			if (array_complete) begin
				array_complete = 1'b0;
				loaded_count = 0;
			end
			// a full store drops the value but still honors the last mark
			if (loaded_count < STORE_DEPTH) begin
				prev = (loaded_count == 0) ? '0 : prefix_copy[loaded_count-1];
				element_copy[loaded_count] = it.value;
				prefix_copy[loaded_count] = gcd_of(prev, it.value);
				loaded_count++;
			end
			if (it.last) begin
				acc = '0;
				for (int i = int'(loaded_count) - 1; i >= 0; i--) begin
					acc = gcd_of(acc, element_copy[i]);
					suffix_copy[i] = acc;
				end
				array_complete = 1'b1;
				arrays_done++;
			end
		end else begin
			queries_taken++;
			res.gcd = '0;
			res.err = 1'b0;
			if (!array_complete || it.lpos == 0 || it.rpos == 0 ||
					it.lpos > loaded_count || it.rpos > loaded_count) begin
				res.err = 1'b1;
			end else begin
				pre_g = (it.lpos >= 2) ? prefix_copy[it.lpos-2] : '0;
				suf_g = (it.rpos < loaded_count) ? suffix_copy[it.rpos] : '0;
				res.gcd = gcd_of(pre_g, suf_g);
			end
			expected_gcds.push_back(res);
		end
	endtask

	// sender: offers queued beats, idles at random
	always @(posedge clk or negedge arst_n) begin : drive_items
		gcd_item_t taken;
		gcd_item_t nxt;
		if (!arst_n) begin
			item_valid <= 1'b0;
			cmd <= psgq_pkg::CMD_LOAD;
			value <= '0;
			is_last <= 1'b0;
			left_pos <= '0;
			right_pos <= '0;
		end else begin
			if (item_valid && !item_stall) begin
				taken.cmd = cmd;
				taken.value = value;
				taken.last = is_last;
				taken.lpos = left_pos;
				taken.rpos = right_pos;
				apply_gcd_beat(taken);
			end
			if (!item_valid || !item_stall) begin
				if (pending_items.size() == 0 || $urandom_range(0, 99) < send_idle_pct) begin
					item_valid <= 1'b0;
				end else begin
					nxt = pending_items.pop_front();
					item_valid <= 1'b1;
					cmd <= nxt.cmd;
					value <= nxt.value;
					is_last <= nxt.last;
					left_pos <= nxt.lpos;
					right_pos <= nxt.rpos;
				end
			end
		end
	end

	// receiver: checks each result beat, stalls at random or for one long hold
	always @(posedge clk or negedge arst_n) begin : check_results
		gcd_result_t exp_res;
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (result_valid && !result_stall) begin
				results_seen++;
				if (error) error_results++;
				if (expected_gcds.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected result beat: gcd_out=%0d error=%0b", gcd_out, error);
				end else begin
					exp_res = expected_gcds.pop_front();
					if (gcd_out !== exp_res.gcd || error !== exp_res.err) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("result mismatch: expected gcd=%0d error=%0b, got gcd=%0d error=%0b",
								exp_res.gcd, exp_res.err, gcd_out, error);
					end
				end
			end
			if (hold_go && !hold_done) begin
				hold_done <= 1'b1;
				hold_left <= HOLD_CYCLES;
				result_stall <= 1'b1;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				result_stall <= 1'b1;
			end else begin
				result_stall <= ($urandom_range(0, 99) < recv_stall_pct);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", CYCLE_LIMIT);
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic push_item(logic c, logic [VAL_W-1:0] v, logic lst,
			logic [POS_W-1:0] l, logic [POS_W-1:0] r);
		gcd_item_t it;
		it.cmd = c;
		it.value = v;
		it.last = lst;
		it.lpos = l;
		it.rpos = r;
		pending_items.push_back(it);
	endtask

	// position fields of a load and value/last of a query carry noise
	task automatic push_load(logic [VAL_W-1:0] v, logic lst);
		push_item(psgq_pkg::CMD_LOAD, v, lst, POS_W'($urandom), POS_W'($urandom));
	endtask

	task automatic push_query(logic [POS_W-1:0] l, logic [POS_W-1:0] r);
		push_item(psgq_pkg::CMD_QUERY, VAL_W'($urandom), 1'($urandom), l, r);
	endtask

	// mostly complete arrays with a shared factor followed by queries, some noise
	task automatic push_random_items(int target);
		int made;
		int n;
		int nq;
		int l;
		int r;
		int unsigned f;
		int unsigned v;
		made = 0;
		while (made < target) begin
			if ($urandom_range(0, 99) < 80) begin
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
				case ($urandom_range(0, 3))
					0: f = 1;
					1: f = $urandom_range(2, 64);
					2: f = 1 << $urandom_range(1, 24);
					default: f = $urandom_range(1000, 100000);
				endcase
				for (int i = 0; i < n; i++) begin
					if ($urandom_range(0, 15) == 0)
						v = 0;
					else if ($urandom_range(0, 15) == 0)
						v = $urandom;
					else
						v = f * $urandom_range(1, 32'h7FFF_FFFF / f);
					push_load(VAL_W'(v), i == n - 1);
				end
				nq = $urandom_range(2, 8);
				for (int q = 0; q < nq; q++) begin
					case ($urandom_range(0, 9))
						0, 1, 2, 3, 4, 5: begin
							l = $urandom_range(1, n);
							r = $urandom_range(l, n);
						end
						6: begin
							l = $urandom_range(1, n);
							r = $urandom_range(1, n);
						end
						7: begin
							l = $urandom_range(0, n + 1);
							r = $urandom_range(0, n + 1);
						end
						default: begin
							l = $urandom_range(0, 2047);
							r = $urandom_range(0, 2047);
						end
					endcase
					push_query(POS_W'(l), POS_W'(r));
				end
				made += n + nq;
			end else begin
				// loads left open, so the following query finds no ready array
				if ($urandom_range(0, 1) == 1) begin
					n = $urandom_range(1, 3);
					for (int i = 0; i < n; i++)
						push_load(VAL_W'($urandom), 1'b0);
					made += n;
				end
				push_query(POS_W'($urandom), POS_W'($urandom_range(0, 4)));
				made++;
			end
		end
	endtask

	task automatic wait_sent();
		while (pending_items.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		// directed: no array, open array, extremes and range corners
		push_query(11'd1, 11'd1);
		push_load(31'h7FFF_FFFF, 1'b0);
		push_query(11'd1, 11'd1);
		push_load(31'd0, 1'b0);
		push_load(31'h7FFF_FFFE, 1'b0);
		push_load(31'd12, 1'b0);
		push_load(31'd18, 1'b1);
		push_query(11'd1, 11'd5);
		push_query(11'd1, 11'd1);
		push_query(11'd5, 11'd5);
		push_query(11'd2, 11'd4);
		push_query(11'd3, 11'd2);
		push_query(11'd0, 11'd3);
		push_query(11'd3, 11'd0);
		push_query(11'd6, 11'd2);
		push_query(11'd2, 11'd6);
		push_query(11'h7FF, 11'h7FF);
		push_query(11'd1024, 11'd1);
		// single-element array restarts the store
		push_load(31'd42, 1'b1);
		push_query(11'd1, 11'd1);
		push_query(11'd1, 11'd2);
		push_load(31'd30, 1'b0);
		push_query(11'd1, 11'd1);
		push_load(31'd45, 1'b1);
		push_query(11'd1, 11'd1);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		push_random_items(120);
		wait_sent();
		send_idle_pct <= 79;
		recv_stall_pct <= 13;
		push_random_items(120);
		wait_sent();
		send_idle_pct <= 0;
		recv_stall_pct <= 0;

		// long receiver hold while a burst of queries backs up the input
		for (int i = 0; i < 4; i++)
			push_load(VAL_W'(10 * $urandom_range(1, 1000)), i == 3);
		for (int i = 0; i < 16; i++)
			push_query(POS_W'($urandom_range(1, 4)), POS_W'($urandom_range(1, 4)));
		@(posedge clk);
		hold_go <= 1'b1;
		push_random_items(110);

		wait_sent();
		while (item_valid || expected_gcds.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("run covered %0d loads, %0d queries and %0d completed arrays under mixed stalls",
			loads_taken, queries_taken, arrays_done);
		$display("checked %0d result beats, %0d flagged as errors, %0d mismatches",
			results_seen, error_results, mismatch_count);
		if (mismatch_count == 0 && expected_gcds.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/psgq_pkg.sv
rtl/core/psgq_gcd.sv
rtl/core/psgq_ram.sv
rtl/core/prefix_suffix_gcd_query_unit.sv
tb/prefix_suffix_gcd_query_unit_tb.sv
